@@ hdl/object_bearing_window_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the object bearing window unit
// Immediate-implication and next-cycle-implication checks, reset gated.
// ----------------------------------------------------------------------------
`ifndef OBJECT_BEARING_WINDOW_UNIT_ASSERT_SVH
`define OBJECT_BEARING_WINDOW_UNIT_ASSERT_SVH

// same-cycle implication
`define OBW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OBW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/obw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obw_pkg
// Shared constants, angle table and stage control type.
// ----------------------------------------------------------------------------
package obw_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int COORD_BITS_DEF    = 14;
    localparam int TABLE_LEN         = 24;
    localparam int GUARD_BITS        = 8;
    localparam int GROW_BITS         = 3;   // CORDIC gain and sqrt(2) headroom
    localparam int Z_W               = 32;  // binary angle, 2^-32 turn
    localparam int ANGLE_W           = 16;
    localparam int DIST_W            = 15;
    localparam int CFG_W             = 14;
    localparam int M_DATA_W          = 80;
    localparam int DIST_GAIN         = 39797;  // 0.60725 in Q16
    localparam int BEAR_SCALE        = 36000;
    localparam int HALF_TURN         = 18000;
    localparam int FULL_TURN         = 36000;
    localparam logic [CFG_W-1:0] HALF_WIDTH_RESET = 14'd500;
    localparam logic [Z_W-1:0]   Z_HALF_TURN      = 32'h8000_0000;

    localparam logic [Z_W-1:0] ATAN_TURNS [0:TABLE_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic valid;
        logic coincident;   // dx == dy == 0
    } obw_ctl_t;

endpackage

@@ hdl/obw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obw_front
// Delta stage: forms dx/dy, adds guard bits, folds left half plane.
// ----------------------------------------------------------------------------
module obw_front #(
    parameter int COORD_BITS = obw_pkg::COORD_BITS_DEF,
    parameter int XW         = COORD_BITS + 1 + obw_pkg::GUARD_BITS + obw_pkg::GROW_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        observer_x,
    input  logic signed [COORD_BITS-1:0]        observer_y,
    input  logic signed [obw_pkg::ANGLE_W-1:0]  observer_heading,
    input  logic signed [COORD_BITS-1:0]        target_x,
    input  logic signed [COORD_BITS-1:0]        target_y,
    output obw_pkg::obw_ctl_t                   out_ctl,
    input  logic                                out_ready,
    output logic signed [XW-1:0]                out_x,
    output logic signed [XW-1:0]                out_y,
    output logic [obw_pkg::Z_W-1:0]             out_z,
    output logic signed [obw_pkg::ANGLE_W-1:0]  out_heading
);

    logic                               valid_reg;
    logic                               coinc_reg, coinc_next;
    logic signed [XW-1:0]               x_reg, x_next;
    logic signed [XW-1:0]               y_reg, y_next;
    logic [obw_pkg::Z_W-1:0]            z_reg, z_next;
    logic signed [obw_pkg::ANGLE_W-1:0] hd_reg;
    logic signed [COORD_BITS:0]         dx, dy;
    logic signed [XW-1:0]               xg, yg;

    always_comb begin
        dx = $signed({target_x[COORD_BITS-1], target_x})
             - $signed({observer_x[COORD_BITS-1], observer_x});
        dy = $signed({target_y[COORD_BITS-1], target_y})
             - $signed({observer_y[COORD_BITS-1], observer_y});
        xg = XW'(dx) <<< obw_pkg::GUARD_BITS;
        yg = XW'(dy) <<< obw_pkg::GUARD_BITS;
        coinc_next = (dx == '0) && (dy == '0);
        if (dx[COORD_BITS]) begin
            x_next = -xg;
            y_next = -yg;
            z_next = obw_pkg::Z_HALF_TURN;
        end else begin
            x_next = xg;
            y_next = yg;
            z_next = '0;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            coinc_reg <= coinc_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            hd_reg    <= observer_heading;
        end
    end

    assign out_ctl.valid      = valid_reg;
    assign out_ctl.coincident = coinc_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_z       = z_reg;
    assign out_heading = hd_reg;

endmodule

@@ hdl/obw_cordic_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obw_cordic_stage
// One registered vectoring micro-rotation, shift and angle set by IDX.
// ----------------------------------------------------------------------------
module obw_cordic_stage #(
    parameter int XW  = 26,
    parameter int IDX = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  obw_pkg::obw_ctl_t                   in_ctl,
    output logic                                in_ready,
    input  logic signed [XW-1:0]                in_x,
    input  logic signed [XW-1:0]                in_y,
    input  logic [obw_pkg::Z_W-1:0]             in_z,
    input  logic signed [obw_pkg::ANGLE_W-1:0]  in_heading,
    output obw_pkg::obw_ctl_t                   out_ctl,
    input  logic                                out_ready,
    output logic signed [XW-1:0]                out_x,
    output logic signed [XW-1:0]                out_y,
    output logic [obw_pkg::Z_W-1:0]             out_z,
    output logic signed [obw_pkg::ANGLE_W-1:0]  out_heading
);

    localparam logic [obw_pkg::Z_W-1:0] ATAN_I = obw_pkg::ATAN_TURNS[IDX];

    logic                               valid_reg;
    logic                               coinc_reg;
    logic signed [XW-1:0]               x_reg, x_next;
    logic signed [XW-1:0]               y_reg, y_next;
    logic [obw_pkg::Z_W-1:0]            z_reg, z_next;
    logic signed [obw_pkg::ANGLE_W-1:0] hd_reg;
    logic signed [XW-1:0]               xs, ys;

    always_comb begin
        xs = in_x >>> IDX;
        ys = in_y >>> IDX;
        if (!in_y[XW-1]) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN_I;
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN_I;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_ctl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_ctl.valid) begin
            coinc_reg <= in_ctl.coincident;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            hd_reg    <= in_heading;
        end
    end

    assign out_ctl.valid      = valid_reg;
    assign out_ctl.coincident = coinc_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign out_z       = z_reg;
    assign out_heading = hd_reg;

endmodule

@@ hdl/obw_post.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obw_post
// Scaling back end: multiply, round/wrap/saturate, heading and window, output.
// ----------------------------------------------------------------------------
module obw_post #(
    parameter int XW = 26
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  obw_pkg::obw_ctl_t                   in_ctl,
    output logic                                in_ready,
    input  logic signed [XW-1:0]                in_x,
    input  logic [obw_pkg::Z_W-1:0]             in_z,
    input  logic signed [obw_pkg::ANGLE_W-1:0]  in_heading,
    input  logic [obw_pkg::CFG_W-1:0]           half_width,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [obw_pkg::M_DATA_W-1:0]        m_tdata
);

    localparam int PW   = XW - 1 + 16;      // distance product
    localparam int DQ_W = PW + 1 - 24;      // after rounding shift
    localparam int BPW  = 48;               // bearing product
    localparam logic signed [BPW-1:0] SCALE_B = BPW'(obw_pkg::BEAR_SCALE);
    localparam logic signed [BPW-1:0] ROUND_B = BPW'(64'h8000_0000);
    localparam logic [PW-1:0]         GAIN_D  = PW'(obw_pkg::DIST_GAIN);
    localparam logic [PW:0]           ROUND_D = (PW+1)'(1 << 23);
    localparam logic signed [obw_pkg::ANGLE_W-1:0] HALF_A = 16'sd18000;
    localparam logic signed [16:0] HALF_17 = 17'sd18000;
    localparam logic signed [16:0] FULL_17 = 17'sd36000;
    localparam logic signed [16:0] MAX_17  = 17'sd32767;
    localparam logic signed [16:0] MIN_17  = -17'sd32768;

    // ---- stage 1: products
    logic                   v1_reg, r1;
    logic                   c1_reg;
    logic signed [BPW-1:0]  bprod_reg, bprod_next;
    logic [PW-1:0]          dprod_reg, dprod_next;
    logic signed [15:0]     hd1_reg;
    logic [XW-2:0]          x_pos;

    // ---- stage 2: bearing and distance
    logic                   v2_reg, r2;
    logic signed [15:0]     bear_reg, bear_next;
    logic [obw_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic signed [15:0]     hd2_reg;
    logic signed [BPW-1:0]  bsum;
    logic signed [15:0]     bq;
    logic [PW:0]            dsum;
    logic [DQ_W+15:0]       dq_ext;

    // ---- stage 3: output register
    logic                   v3_reg, r3;
    logic [obw_pkg::M_DATA_W-1:0] data_reg, data_next;
    logic signed [16:0]     rel_raw, ws_raw, we_raw, bear17;
    logic signed [15:0]     rel, ws, we;

    assign r3       = !v3_reg || m_tready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb begin
        x_pos      = in_x[XW-1] ? '0 : in_x[XW-2:0];
        bprod_next = BPW'($signed(in_z)) * SCALE_B;
        dprod_next = {16'd0, x_pos} * GAIN_D;
    end

    always_comb begin
        bsum = bprod_reg + ROUND_B;
        bq   = bsum[BPW-1:BPW-16];
        if (c1_reg) begin
            bear_next = '0;
        end else if (bq == -HALF_A) begin
            bear_next = HALF_A;
        end else begin
            bear_next = bq;
        end
        dsum   = {1'b0, dprod_reg} + ROUND_D;
        dq_ext = {16'd0, dsum[PW:24]};
        if (c1_reg) begin
            dist_next = '0;
        end else if (dq_ext > (DQ_W+16)'(32767)) begin
            dist_next = '1;
        end else begin
            dist_next = dq_ext[obw_pkg::DIST_W-1:0];
        end
    end

    always_comb begin
        bear17  = {bear_reg[15], bear_reg};
        rel_raw = bear17 - {hd2_reg[15], hd2_reg};
        if (rel_raw > HALF_17) begin
            rel_raw = rel_raw - FULL_17;
        end else if (rel_raw <= -HALF_17) begin
            rel_raw = rel_raw + FULL_17;
        end
        rel    = rel_raw[15:0];
        ws_raw = bear17 - {3'b000, half_width};
        we_raw = bear17 + {3'b000, half_width};
        ws = (ws_raw < MIN_17) ? 16'sh8000 : ws_raw[15:0];
        we = (we_raw > MAX_17) ? 16'sh7fff : we_raw[15:0];
        data_next = {1'b0, we, ws, dist_reg, rel, bear_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) begin
                v1_reg <= in_ctl.valid;
            end
            if (r2) begin
                v2_reg <= v1_reg;
            end
            if (r3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (r1 && in_ctl.valid) begin
            c1_reg    <= in_ctl.coincident;
            bprod_reg <= bprod_next;
            dprod_reg <= dprod_next;
            hd1_reg   <= in_heading;
        end
        if (r2 && v1_reg) begin
            bear_reg <= bear_next;
            dist_reg <= dist_next;
            hd2_reg  <= hd1_reg;
        end
        if (r3 && v2_reg) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = data_reg;

endmodule

@@ hdl/object_bearing_window_unit.sv @@
// Throughput: one transfer per cycle while m_tready does not hold off the output;
// every stage is a register with its own valid.
// Bubbles collapse: a stage takes new data whenever it is empty or its output moves.
// Reset (aresetn low, synchronous): all valid bits clear, half width returns to 500.
// The configuration port is always ready; writes are registered on the accepting edge.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// object_bearing_window_unit
// Bearing, relative bearing, distance and search window to one target,
// using a fully unrolled CORDIC vectoring pipeline.
// ----------------------------------------------------------------------------
`include "object_bearing_window_unit_assert.svh"

module object_bearing_window_unit #(
    parameter int CORDIC_STAGES = obw_pkg::CORDIC_STAGES_DEF,   // 8 .. 24
    parameter int COORD_BITS    = obw_pkg::COORD_BITS_DEF       // 10 .. 20
) (
    input  logic aclk,
    input  logic aresetn,
    // input stream
    input  logic s_tvalid,
    output logic s_tready,
    // observer_x, observer_y, observer_heading, target_x, target_y, zero pad
    input  logic [((4*COORD_BITS+obw_pkg::ANGLE_W+7)/8)*8-1:0] s_tdata,
    // result stream
    output logic m_tvalid,
    input  logic m_tready,
    // absolute_bearing, relative_bearing, target_distance, window_start,
    // window_end, zero pad
    output logic [obw_pkg::M_DATA_W-1:0] m_tdata,
    // configuration: window_half_width
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [obw_pkg::CFG_W-1:0]  cfg_data
);

    localparam int XW = COORD_BITS + 1 + obw_pkg::GUARD_BITS + obw_pkg::GROW_BITS;
    localparam int AW = obw_pkg::ANGLE_W;

    // field offsets in s_tdata
    localparam int OFS_OY = COORD_BITS;
    localparam int OFS_HD = 2 * COORD_BITS;
    localparam int OFS_TX = 2 * COORD_BITS + AW;
    localparam int OFS_TY = 3 * COORD_BITS + AW;

    localparam logic signed [AW-1:0] HALF_A = 16'sd18000;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [obw_pkg::CFG_W-1:0] window_half_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_half_width_reg <= obw_pkg::HALF_WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            window_half_width_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline chain: front end, CORDIC_STAGES rotations, back end.
    // Index k carries the output of stage k-1 (0 = front end).
    // ------------------------------------------------------------------
    obw_pkg::obw_ctl_t      ctl_c   [0:CORDIC_STAGES];
    logic                   rdy_c   [0:CORDIC_STAGES];
    logic signed [XW-1:0]   x_c     [0:CORDIC_STAGES];
    logic signed [XW-1:0]   y_c     [0:CORDIC_STAGES];
    logic [obw_pkg::Z_W-1:0] z_c    [0:CORDIC_STAGES];
    logic signed [AW-1:0]   hd_c    [0:CORDIC_STAGES];

    obw_front #(
        .COORD_BITS (COORD_BITS),
        .XW         (XW)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .observer_x       (s_tdata[COORD_BITS-1:0]),
        .observer_y       (s_tdata[OFS_OY +: COORD_BITS]),
        .observer_heading (s_tdata[OFS_HD +: AW]),
        .target_x         (s_tdata[OFS_TX +: COORD_BITS]),
        .target_y         (s_tdata[OFS_TY +: COORD_BITS]),
        .out_ctl          (ctl_c[0]),
        .out_ready        (rdy_c[0]),
        .out_x            (x_c[0]),
        .out_y            (y_c[0]),
        .out_z            (z_c[0]),
        .out_heading      (hd_c[0])
    );

    // One micro-rotation per register stage; shift and angle are per-stage constants.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
        obw_cordic_stage #(
            .XW  (XW),
            .IDX (k)
        ) u_stage (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .in_ctl      (ctl_c[k]),
            .in_ready    (rdy_c[k]),
            .in_x        (x_c[k]),
            .in_y        (y_c[k]),
            .in_z        (z_c[k]),
            .in_heading  (hd_c[k]),
            .out_ctl     (ctl_c[k+1]),
            .out_ready   (rdy_c[k+1]),
            .out_x       (x_c[k+1]),
            .out_y       (y_c[k+1]),
            .out_z       (z_c[k+1]),
            .out_heading (hd_c[k+1])
        );
    end

    // Back end: bearing scale and distance gain (1 mult each), wrap and
    // saturate, then relative bearing and window into the output register.
    // y of the last rotation is not needed.
    obw_post #(
        .XW (XW)
    ) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_ctl     (ctl_c[CORDIC_STAGES]),
        .in_ready   (rdy_c[CORDIC_STAGES]),
        .in_x       (x_c[CORDIC_STAGES]),
        .in_z       (z_c[CORDIC_STAGES]),
        .in_heading (hd_c[CORDIC_STAGES]),
        .half_width (window_half_width_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic signed [AW-1:0] chk_abs, chk_rel;
    logic                 chk_y_unused;

    assign chk_abs = m_tdata[AW-1:0];
    assign chk_rel = m_tdata[2*AW-1:AW];
    assign chk_y_unused = ^y_c[CORDIC_STAGES];

    `OBW_ASSERT_NEXT(a_cfg_write, aclk, aresetn, cfg_valid && cfg_ready,
        window_half_width_reg == $past(cfg_data), "half width write lost")
    `OBW_ASSERT_NOW(a_abs_range, aclk, aresetn, m_tvalid,
        (chk_abs > -HALF_A) && (chk_abs <= HALF_A), "absolute bearing not wrapped")
    `OBW_ASSERT_NOW(a_rel_range, aclk, aresetn, m_tvalid,
        (chk_rel > -HALF_A) && (chk_rel <= HALF_A), "relative bearing not wrapped")
    `OBW_ASSERT_NOW(a_empty_ready, aclk, aresetn, !m_tvalid && (chk_y_unused || 1'b1),
        s_tready, "input stalled while output empty")

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for object_bearing_window_unit. A fixed-point CORDIC
// predictor in the bench computes bearing, relative bearing, distance and
// search window for every accepted fix. A scoreboard checks each result
// transfer against the oldest prediction. The run covers directed geometry
// and heading cases, several half widths up to the saturating extremes,
// random fixes with random idling on both sides, and one long receiver
// hold-off that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COORD_W    = 14;
    localparam int S_DATA_W   = ((4*COORD_W + obw_pkg::ANGLE_W + 7)/8)*8;
    localparam int PIPE_LAT   = 20;
    localparam int CORDIC_N   = 16;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 200;     // long receiver hold-off, in cycles
    localparam int IDLE_PCT   = 30;

    // one input fix, first field in the low bits
    typedef struct packed {
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_x;
        logic signed [15:0]        observer_heading;
        logic signed [COORD_W-1:0] observer_y;
        logic signed [COORD_W-1:0] observer_x;
    } fix_t;

    // one result, first field in the low bits, one pad bit on top
    typedef struct packed {
        logic               pad;
        logic signed [15:0] window_end;
        logic signed [15:0] window_start;
        logic [14:0]        target_distance;
        logic signed [15:0] relative_bearing;
        logic signed [15:0] absolute_bearing;
    } sighting_t;

    // atan(2^-i) as a binary angle, 2^-32 turn
    localparam logic [31:0] ARC_STEP [0:CORDIC_N-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [S_DATA_W-1:0]          s_tdata;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [obw_pkg::M_DATA_W-1:0] m_tdata;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [obw_pkg::CFG_W-1:0]    cfg_data;

    // predictions waiting for their result transfer
    sighting_t                 pending_sightings[$];
    logic [obw_pkg::CFG_W-1:0] bearing_half_width;
    int                        mismatch_count = 0;
    int                        cycle_count = 0;

    // idling control, written by the tests
    bit tx_idle_on = 1'b0;
    bit rx_idle_on = 1'b0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    object_bearing_window_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint wrap_half_turn(input longint a);
        longint r;
        r = a;
        while (r > obw_pkg::HALF_TURN) r -= obw_pkg::FULL_TURN;
        while (r <= -obw_pkg::HALF_TURN) r += obw_pkg::FULL_TURN;
        return r;
    endfunction

    function automatic longint clamp16(input longint a);
        if (a > 32767) return 32767;
        if (a < -32768) return -32768;
        return a;
    endfunction

    function automatic sighting_t predict_sighting(input fix_t f,
                                                   input logic [13:0] half_w);
        longint    dx, dy, vx, vy, sx, sy, ang, bear, reach;
        logic [31:0] z;
        sighting_t r;
        dx    = longint'(f.target_x) - longint'(f.observer_x);
        dy    = longint'(f.target_y) - longint'(f.observer_y);
        bear  = 0;
        reach = 0;
        if (dx != 0 || dy != 0) begin
            vx = dx * 256;                 // 8 guard bits
            vy = dy * 256;
            z  = 32'h0;
            // left half plane: rotate by half a turn first
            if (vx < 0) begin
                vx = -vx;
                vy = -vy;
                z  = 32'h8000_0000;
            end
            for (int i = 0; i < CORDIC_N; i++) begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy >= 0) begin
                    vx = vx + sy;
                    vy = vy - sx;
                    z  = z + ARC_STEP[i];
                end else begin
                    vx = vx - sy;
                    vy = vy + sx;
                    z  = z - ARC_STEP[i];
                end
            end
            ang  = longint'($signed(z));
            bear = wrap_half_turn((ang * 36000 + 64'sh8000_0000) >>> 32);
            if (vx < 0) vx = 0;
            // gain removal and guard bits in one scale
            reach = (vx * obw_pkg::DIST_GAIN + 64'sh80_0000) >>> 24;
            if (reach > 32767) reach = 32767;
        end
        r.pad              = 1'b0;
        r.absolute_bearing = 16'(bear);
        r.relative_bearing = 16'(wrap_half_turn(bear - longint'(f.observer_heading)));
        r.target_distance  = 15'(reach);
        r.window_start     = 16'(clamp16(bear - longint'(half_w)));
        r.window_end       = 16'(clamp16(bear + longint'(half_w)));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_served != hold_ticket) begin
            hold_served = hold_ticket;
            hold_left   = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_on) begin
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard: each result transfer against the oldest prediction
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input int expv, input int gotv);
        if (expv != gotv) begin
            $error("%s: expected %0d, actual %0d", name, expv, gotv);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        sighting_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = sighting_t'(m_tdata);
            if (pending_sightings.size() == 0) begin
                $error("result transfer with no prediction waiting: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_sightings.pop_front();
                compare_field("absolute_bearing", want.absolute_bearing,
                              got.absolute_bearing);
                compare_field("relative_bearing", want.relative_bearing,
                              got.relative_bearing);
                compare_field("target_distance", want.target_distance,
                              got.target_distance);
                compare_field("window_start", want.window_start, got.window_start);
                compare_field("window_end", want.window_end, got.window_end);
            end
        end
    end

    // runaway guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side; every task is entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic offer_fix(input fix_t f);
        while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f;
        do @(posedge aclk); while (!s_tready);
        pending_sightings.push_back(predict_sighting(f, bearing_half_width));
        @(negedge aclk);
    endtask

    task automatic offer_coords(input int ox, input int oy, input int hd,
                                input int tx, input int ty);
        fix_t f;
        f.observer_x       = COORD_W'(ox);
        f.observer_y       = COORD_W'(oy);
        f.observer_heading = 16'(hd);
        f.target_x         = COORD_W'(tx);
        f.target_y         = COORD_W'(ty);
        offer_fix(f);
    endtask

    // register writes only with the pipeline empty
    task automatic write_half_width(input logic [obw_pkg::CFG_W-1:0] hw);
        s_tvalid <= 1'b0;
        while (pending_sightings.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= hw;
        do @(posedge aclk); while (!cfg_ready);
        bearing_half_width = hw;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic fix_t random_fix();
        fix_t f;
        int   pick;
        pick = $urandom_range(99);
        f.observer_x       = COORD_W'($urandom);
        f.observer_y       = COORD_W'($urandom);
        f.observer_heading = 16'($urandom);
        f.target_x         = COORD_W'($urandom);
        f.target_y         = COORD_W'($urandom);
        if (pick < 20) begin
            // target close to the observer, coincident now and then
            f.target_x = f.observer_x + COORD_W'($urandom_range(6)) - 14'sd3;
            f.target_y = f.observer_y + COORD_W'($urandom_range(6)) - 14'sd3;
        end else if (pick < 55) begin
            // heading kept inside the nominal range
            f.observer_heading = 16'($urandom_range(36000)) - 16'sd18000;
        end
        return f;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // geometry and heading corners at the reset half width
    task automatic test_directed_cases();
        offer_coords(0, 0, 0, 0, 0);                    // coincident points
        offer_coords(-8192, -8192, -32768, -8192, -8192);
        offer_coords(8191, 8191, 32767, 8191, 8191);
        offer_coords(-8192, 0, 0, 8191, 0);             // +x axis, longest
        offer_coords(8191, 0, 0, -8192, 0);             // -x axis, half turn
        offer_coords(0, -8192, 9000, 0, 8191);          // +y axis
        offer_coords(0, 8191, -9000, 0, -8192);         // -y axis
        offer_coords(-8192, -8192, 18000, 8191, 8191);  // corner diagonals
        offer_coords(8191, 8191, -18000, -8192, -8192);
        offer_coords(-8192, 8191, 18001, 8191, -8192);
        offer_coords(8191, -8192, -17999, -8192, 8191);
        offer_coords(1, 0, 0, 0, 0);                    // dx = -1
        offer_coords(1, 1, 0, 0, 0);                    // dx = dy = -1
        offer_coords(0, 0, 0, 1, 0);                    // dx = +1
        offer_coords(0, 1, 0, 0, 0);                    // dy = -1 on the axis
        offer_coords(5, 5, 32767, 5, 5);                // coincident, odd heading
        offer_coords(0, 0, -32768, 8191, 1);
        offer_coords(0, 0, 12345, -8192, -1);           // just above minus half turn
        offer_coords(0, 0, -12345, -8192, 1);           // just below half turn
        offer_coords(100, -200, 4500, 8191, -8192);
    endtask

    // half width at its maximum, saturating both window ends, and at zero
    task automatic test_half_width_extremes();
        write_half_width(14'h3FFF);
        offer_coords(8191, 0, 0, -8192, 0);
        offer_coords(0, 0, 0, -8192, -1);
        offer_coords(0, 0, 0, 0, 0);
        offer_coords(0, 8191, 0, 0, -8192);
        offer_coords(-8192, 0, 0, 8191, 5);
        offer_coords(0, 0, 0, 8191, 8191);
        write_half_width(14'd0);
        offer_coords(8191, 0, 0, -8192, 0);
        offer_coords(0, 0, 0, -8192, -1);
        offer_coords(0, 0, 0, 0, 0);
        offer_coords(-8192, 0, -32768, 8191, 0);
        offer_coords(0, 0, 777, 3, -4);
        offer_coords(0, -8192, 0, 0, 8191);
    endtask

    // random fixes over several half widths, one phase without idling
    task automatic test_random_fixes();
        logic [obw_pkg::CFG_W-1:0] widths [5];
        widths = '{14'd9000, 14'd1, 14'd500, 14'h3FFF, 14'd0};
        widths[2] = 14'($urandom_range(16383));
        for (int p = 0; p < 5; p++) begin
            write_half_width(widths[p]);
            tx_idle_on = (p != 3);
            rx_idle_on = (p != 3);
            repeat (165) offer_fix(random_fix());
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        write_half_width(14'd2500);
        tx_idle_on  = 1'b0;
        rx_idle_on  = 1'b0;
        hold_ticket = hold_ticket + 1;
        repeat (80) offer_fix(random_fix());
        rx_idle_on  = 1'b1;
    endtask

    initial begin
        aresetn            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        bearing_half_width = obw_pkg::HALF_WIDTH_RESET;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_directed_cases();
        test_half_width_extremes();
        test_random_fixes();
        test_backpressure();

        s_tvalid <= 1'b0;
        while (pending_sightings.size() != 0) @(negedge aclk);
        repeat (2 * PIPE_LAT) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
